### hdl/erm_pkg.sv
// Shared types, convention codes and the rounding multiply for the rotation matrix pipeline.
package erm_pkg;

   typedef enum logic [2:0] {
      CONV_XZX = 3'd0,
      CONV_XYX = 3'd1,
      CONV_YXY = 3'd2,
      CONV_YZY = 3'd3,
      CONV_ZYZ = 3'd4,
      CONV_ZXZ = 3'd5,
      CONV_XYZ = 3'd6,
      CONV_ZYX = 3'd7
   } conv_type;

   typedef logic signed [15:0] q15_type;
   typedef logic signed [16:0] prod_type;

   typedef struct packed {
      q15_type  c1;
      q15_type  c2;
      q15_type  c3;
      q15_type  s1;
      q15_type  s2;
      q15_type  s3;
      conv_type conv;
   } angle_type;

   typedef struct packed {
      prod_type c1c2;
      prod_type c1c3;
      prod_type c1s2;
      prod_type c1s3;
      prod_type c2c3;
      prod_type c2s1;
      prod_type c2s3;
      prod_type c3s1;
      prod_type c3s2;
      prod_type s1s2;
      prod_type s1s3;
      prod_type s2s3;
   } pair_type;

   typedef struct packed {
      pair_type pair;
      q15_type  c2;
      q15_type  c3;
      q15_type  s1;
      q15_type  s2;
      q15_type  s3;
      conv_type conv;
   } stage1_type;

   typedef struct packed {
      prod_type c1c2c3;
      prod_type c1c2s3;
      prod_type c2c3s1;
      prod_type c2s1s3;
      prod_type c3s1s2;
      prod_type s1s2s3;
      prod_type c1c3s2;
      prod_type c1s2s3;
   } triple_type;

   typedef struct packed {
      pair_type   pair;
      triple_type triple;
      q15_type    c2;
      q15_type    s2;
      conv_type   conv;
   } stage2_type;

   typedef logic [8:0][15:0] matrix_type;

   // Q1.15 product rounded to nearest with ties toward plus infinity.
   function automatic prod_type erm_mul(input prod_type a, input q15_type b);
      logic signed [33:0] p;
      p = 34'(a) * 34'(b);
      p = p + 34'sd16384;
      return p[31:15];
   endfunction

endpackage

### hdl/erm_pair_stage.sv
// First pipeline stage: the twelve rounded two-factor products.
module erm_pair_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  erm_pkg::angle_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output erm_pkg::stage1_type out_data
);

   logic                valid_ff;
   erm_pkg::stage1_type data_ff;
   erm_pkg::stage1_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.pair.c1c2 = erm_pkg::erm_mul(17'(in_data.c1), in_data.c2);
      data_in.pair.c1c3 = erm_pkg::erm_mul(17'(in_data.c1), in_data.c3);
      data_in.pair.c1s2 = erm_pkg::erm_mul(17'(in_data.c1), in_data.s2);
      data_in.pair.c1s3 = erm_pkg::erm_mul(17'(in_data.c1), in_data.s3);
      data_in.pair.c2c3 = erm_pkg::erm_mul(17'(in_data.c2), in_data.c3);
      data_in.pair.c2s1 = erm_pkg::erm_mul(17'(in_data.c2), in_data.s1);
      data_in.pair.c2s3 = erm_pkg::erm_mul(17'(in_data.c2), in_data.s3);
      data_in.pair.c3s1 = erm_pkg::erm_mul(17'(in_data.c3), in_data.s1);
      data_in.pair.c3s2 = erm_pkg::erm_mul(17'(in_data.c3), in_data.s2);
      data_in.pair.s1s2 = erm_pkg::erm_mul(17'(in_data.s1), in_data.s2);
      data_in.pair.s1s3 = erm_pkg::erm_mul(17'(in_data.s1), in_data.s3);
      data_in.pair.s2s3 = erm_pkg::erm_mul(17'(in_data.s2), in_data.s3);
      data_in.c2        = in_data.c2;
      data_in.c3        = in_data.c3;
      data_in.s1        = in_data.s1;
      data_in.s2        = in_data.s2;
      data_in.s3        = in_data.s3;
      data_in.conv      = in_data.conv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/erm_triple_stage.sv
// Second pipeline stage: the eight rounded three-factor products.
module erm_triple_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  erm_pkg::stage1_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output erm_pkg::stage2_type out_data
);

   logic                valid_ff;
   erm_pkg::stage2_type data_ff;
   erm_pkg::stage2_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.pair          = in_data.pair;
      data_in.triple.c1c2c3 = erm_pkg::erm_mul(in_data.pair.c1c2, in_data.c3);
      data_in.triple.c1c2s3 = erm_pkg::erm_mul(in_data.pair.c1c2, in_data.s3);
      data_in.triple.c2c3s1 = erm_pkg::erm_mul(in_data.pair.c2c3, in_data.s1);
      data_in.triple.c2s1s3 = erm_pkg::erm_mul(in_data.pair.c2s1, in_data.s3);
      data_in.triple.c3s1s2 = erm_pkg::erm_mul(in_data.pair.c3s1, in_data.s2);
      data_in.triple.s1s2s3 = erm_pkg::erm_mul(in_data.pair.s1s2, in_data.s3);
      data_in.triple.c1c3s2 = erm_pkg::erm_mul(in_data.pair.c1c3, in_data.s2);
      data_in.triple.c1s2s3 = erm_pkg::erm_mul(in_data.pair.c1s2, in_data.s3);
      data_in.c2            = in_data.c2;
      data_in.s2            = in_data.s2;
      data_in.conv          = in_data.conv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/erm_sum_stage.sv
// Last pipeline stage: per-convention entry selection, sums and saturation.
module erm_sum_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  erm_pkg::stage2_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output erm_pkg::matrix_type out_data
);

   typedef logic signed [17:0] wide_type;

   logic                valid_ff;
   erm_pkg::matrix_type data_ff;
   erm_pkg::matrix_type data_in;

   wide_type c2, s2;
   wide_type c1c2, c1c3, c1s2, c1s3, c2c3, c2s1, c2s3, c3s1, c3s2, s1s2, s1s3, s2s3;
   wide_type c1c2c3, c1c2s3, c2c3s1, c2s1s3, c3s1s2, s1s2s3, c1c3s2, c1s2s3;
   wide_type e [9];

   function automatic wide_type ext(input erm_pkg::prod_type v);
      return 18'(v);
   endfunction

   function automatic logic [15:0] sat(input wide_type v);
      logic [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7fff;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      c2     = 18'(in_data.c2);
      s2     = 18'(in_data.s2);
      c1c2   = ext(in_data.pair.c1c2);
      c1c3   = ext(in_data.pair.c1c3);
      c1s2   = ext(in_data.pair.c1s2);
      c1s3   = ext(in_data.pair.c1s3);
      c2c3   = ext(in_data.pair.c2c3);
      c2s1   = ext(in_data.pair.c2s1);
      c2s3   = ext(in_data.pair.c2s3);
      c3s1   = ext(in_data.pair.c3s1);
      c3s2   = ext(in_data.pair.c3s2);
      s1s2   = ext(in_data.pair.s1s2);
      s1s3   = ext(in_data.pair.s1s3);
      s2s3   = ext(in_data.pair.s2s3);
      c1c2c3 = ext(in_data.triple.c1c2c3);
      c1c2s3 = ext(in_data.triple.c1c2s3);
      c2c3s1 = ext(in_data.triple.c2c3s1);
      c2s1s3 = ext(in_data.triple.c2s1s3);
      c3s1s2 = ext(in_data.triple.c3s1s2);
      s1s2s3 = ext(in_data.triple.s1s2s3);
      c1c3s2 = ext(in_data.triple.c1c3s2);
      c1s2s3 = ext(in_data.triple.c1s2s3);

      case (in_data.conv)
         erm_pkg::CONV_XZX: begin
            e[0] = c2;              e[1] = -c3s2;           e[2] = s2s3;
            e[3] = c1s2;            e[4] = c1c2c3 - s1s3;   e[5] = -c3s1 - c1c2s3;
            e[6] = s1s2;            e[7] = c1s3 + c2c3s1;   e[8] = c1c3 - c2s1s3;
         end
         erm_pkg::CONV_XYX: begin
            e[0] = c2;              e[1] = s2s3;            e[2] = c3s2;
            e[3] = s1s2;            e[4] = c1c3 - c2s1s3;   e[5] = -c1s3 - c2c3s1;
            e[6] = -c1s2;           e[7] = c3s1 + c1c2s3;   e[8] = c1c2c3 - s1s3;
         end
         erm_pkg::CONV_YXY: begin
            e[0] = c1c3 - c2s1s3;   e[1] = s1s2;            e[2] = c2c3s1 + c1s3;
            e[3] = s2s3;            e[4] = c2;              e[5] = -c3s2;
            e[6] = -c3s1 - c1c2s3;  e[7] = c1s2;            e[8] = c1c2c3 - s1s3;
         end
         erm_pkg::CONV_YZY: begin
            e[0] = c1c2c3 - s1s3;   e[1] = -c1s2;           e[2] = c3s1 + c1c2s3;
            e[3] = c3s2;            e[4] = c2;              e[5] = s2s3;
            e[6] = -c2c3s1 - c1s3;  e[7] = s1s2;            e[8] = c1c3 - c2s1s3;
         end
         erm_pkg::CONV_ZYZ: begin
            e[0] = c1c2c3 - s1s3;   e[1] = -c3s1 - c1c2s3;  e[2] = c1s2;
            e[3] = c2c3s1 + c1s3;   e[4] = c1c3 - c2s1s3;   e[5] = s1s2;
            e[6] = -c3s2;           e[7] = s2s3;            e[8] = c2;
         end
         erm_pkg::CONV_ZXZ: begin
            e[0] = c1c3 - c2s1s3;   e[1] = -c2c3s1 - c1s3;  e[2] = s1s2;
            e[3] = c3s1 + c1c2s3;   e[4] = c1c2c3 - s1s3;   e[5] = -c1s2;
            e[6] = s2s3;            e[7] = c3s2;            e[8] = c2;
         end
         erm_pkg::CONV_XYZ: begin
            e[0] = c2c3;            e[1] = -c2s3;           e[2] = s2;
            e[3] = c1s3 + c3s1s2;   e[4] = c1c3 - s1s2s3;   e[5] = -c2s1;
            e[6] = s1s3 - c1c3s2;   e[7] = c1s2s3 + c3s1;   e[8] = c1c2;
         end
         default: begin
            e[0] = c1c2;            e[1] = c1s2s3 - c3s1;   e[2] = s1s3 + c1c3s2;
            e[3] = c2s1;            e[4] = c1c3 - s1s2s3;   e[5] = c3s1s2 - c1s3;
            e[6] = -s2;             e[7] = c2s3;            e[8] = c2c3;
         end
      endcase

      for (int k = 0; k < 9; k++) begin
         data_in[k] = sat(e[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/euler_rotation_matrix_top.sv
// Top level of the Euler-angle rotation matrix builder.
//
//   Channel  Direction  Beat contents
//   req_     in         six Q1.15 cosines and sines in tdata, convention code in tuser
//   rsp_     out        nine Q1.15 matrix entries in tdata, row by row
//
// The pipeline has three register stages, and each result is driven from the last of them;
// one beat is taken every cycle while the response side is not stalled.
// The three stages are pair products, triple products, and sum and clamp.
// Reset clears only the stage valid bits; nothing else is held between beats.
// A stage holds its beat while the stage after it is full and stalled, and empty
// stages still take new beats, so a stall on the output loses and repeats nothing.
module euler_rotation_matrix_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // cos_first, cos_second, cos_third, sin_first, sin_second, sin_third
   input  logic [95:0]   req_tdata,
   // convention
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // entry_r0_c0, entry_r0_c1, entry_r0_c2, entry_r1_c0, entry_r1_c1,
   // entry_r1_c2, entry_r2_c0, entry_r2_c1, entry_r2_c2
   output logic [143:0]  rsp_tdata
);

   erm_pkg::angle_type  angle;
   erm_pkg::stage1_type st1_data;
   erm_pkg::stage2_type st2_data;
   erm_pkg::matrix_type matrix;
   logic                st1_valid, st1_ready;
   logic                st2_valid, st2_ready;

   always_comb begin
      angle.c1   = req_tdata[15:0];
      angle.c2   = req_tdata[31:16];
      angle.c3   = req_tdata[47:32];
      angle.s1   = req_tdata[63:48];
      angle.s2   = req_tdata[79:64];
      angle.s3   = req_tdata[95:80];
      angle.conv = erm_pkg::conv_type'(req_tuser);
   end

   erm_pair_stage u_pair (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (angle),
      .out_valid (st1_valid),
      .out_ready (st1_ready),
      .out_data  (st1_data)
   );

   erm_triple_stage u_triple (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st1_valid),
      .in_ready  (st1_ready),
      .in_data   (st1_data),
      .out_valid (st2_valid),
      .out_ready (st2_ready),
      .out_data  (st2_data)
   );

   erm_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st2_valid),
      .in_ready  (st2_ready),
      .in_data   (st2_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (matrix)
   );

   assign rsp_tdata = matrix;

endmodule

### dv/erm_checker.sv
// Checker that predicts each rotation matrix from request beats and compares response beats.
module erm_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [95:0]   req_tdata,
   input  logic [2:0]    req_tuser,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [143:0]  rsp_tdata,
   output int            error_count,
   output int            pending_count,
   output int            checked_count
);

   localparam int MAX_REPORTS = 200;

   logic [143:0] expected_matrices[$];

   function automatic longint q15_round(input longint p);
      return (p + 64'sd16384) >>> 15;
   endfunction

   function automatic longint mul2(input longint a, input longint b);
      return q15_round(a * b);
   endfunction

   function automatic longint mul3(input longint a, input longint b, input longint c);
      return q15_round(mul2(a, b) * c);
   endfunction

   function automatic logic [15:0] clamp_q15(input longint v);
      if (v > 32767) begin
         return 16'h7FFF;
      end
      if (v < -32768) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   function automatic logic [143:0] build_rotation(input logic [95:0] angles,
                                                   input erm_pkg::conv_type conv);
      longint c1, c2, c3, s1, s2, s3;
      longint e[9];
      logic [143:0] matrix;
      c1 = longint'($signed(angles[15:0]));
      c2 = longint'($signed(angles[31:16]));
      c3 = longint'($signed(angles[47:32]));
      s1 = longint'($signed(angles[63:48]));
      s2 = longint'($signed(angles[79:64]));
      s3 = longint'($signed(angles[95:80]));
      case (conv)
         erm_pkg::CONV_XZX: begin
            e[0] = c2;              e[1] = -mul2(c3, s2);
            e[2] = mul2(s2, s3);    e[3] = mul2(c1, s2);
            e[4] = mul3(c1, c2, c3) - mul2(s1, s3);
            e[5] = -mul2(c3, s1) - mul3(c1, c2, s3);
            e[6] = mul2(s1, s2);
            e[7] = mul2(c1, s3) + mul3(c2, c3, s1);
            e[8] = mul2(c1, c3) - mul3(c2, s1, s3);
         end
         erm_pkg::CONV_XYX: begin
            e[0] = c2;              e[1] = mul2(s2, s3);
            e[2] = mul2(c3, s2);    e[3] = mul2(s1, s2);
            e[4] = mul2(c1, c3) - mul3(c2, s1, s3);
            e[5] = -mul2(c1, s3) - mul3(c2, c3, s1);
            e[6] = -mul2(c1, s2);
            e[7] = mul2(c3, s1) + mul3(c1, c2, s3);
            e[8] = mul3(c1, c2, c3) - mul2(s1, s3);
         end
         erm_pkg::CONV_YXY: begin
            e[0] = mul2(c1, c3) - mul3(c2, s1, s3);
            e[1] = mul2(s1, s2);
            e[2] = mul3(c2, c3, s1) + mul2(c1, s3);
            e[3] = mul2(s2, s3);    e[4] = c2;              e[5] = -mul2(c3, s2);
            e[6] = -mul2(c3, s1) - mul3(c1, c2, s3);
            e[7] = mul2(c1, s2);
            e[8] = mul3(c1, c2, c3) - mul2(s1, s3);
         end
         erm_pkg::CONV_YZY: begin
            e[0] = mul3(c1, c2, c3) - mul2(s1, s3);
            e[1] = -mul2(c1, s2);
            e[2] = mul2(c3, s1) + mul3(c1, c2, s3);
            e[3] = mul2(c3, s2);    e[4] = c2;              e[5] = mul2(s2, s3);
            e[6] = -mul3(c2, c3, s1) - mul2(c1, s3);
            e[7] = mul2(s1, s2);
            e[8] = mul2(c1, c3) - mul3(c2, s1, s3);
         end
         erm_pkg::CONV_ZYZ: begin
            e[0] = mul3(c1, c2, c3) - mul2(s1, s3);
            e[1] = -mul2(c3, s1) - mul3(c1, c2, s3);
            e[2] = mul2(c1, s2);
            e[3] = mul3(c2, c3, s1) + mul2(c1, s3);
            e[4] = mul2(c1, c3) - mul3(c2, s1, s3);
            e[5] = mul2(s1, s2);
            e[6] = -mul2(c3, s2);   e[7] = mul2(s2, s3);    e[8] = c2;
         end
         erm_pkg::CONV_ZXZ: begin
            e[0] = mul2(c1, c3) - mul3(c2, s1, s3);
            e[1] = -mul3(c2, c3, s1) - mul2(c1, s3);
            e[2] = mul2(s1, s2);
            e[3] = mul2(c3, s1) + mul3(c1, c2, s3);
            e[4] = mul3(c1, c2, c3) - mul2(s1, s3);
            e[5] = -mul2(c1, s2);
            e[6] = mul2(s2, s3);    e[7] = mul2(c3, s2);    e[8] = c2;
         end
         erm_pkg::CONV_XYZ: begin
            e[0] = mul2(c2, c3);    e[1] = -mul2(c2, s3);   e[2] = s2;
            e[3] = mul2(c1, s3) + mul3(c3, s1, s2);
            e[4] = mul2(c1, c3) - mul3(s1, s2, s3);
            e[5] = -mul2(c2, s1);
            e[6] = mul2(s1, s3) - mul3(c1, c3, s2);
            e[7] = mul3(c1, s2, s3) + mul2(c3, s1);
            e[8] = mul2(c1, c2);
         end
         default: begin
            e[0] = mul2(c1, c2);
            e[1] = mul3(c1, s2, s3) - mul2(c3, s1);
            e[2] = mul2(s1, s3) + mul3(c1, c3, s2);
            e[3] = mul2(c2, s1);
            e[4] = mul2(c1, c3) - mul3(s1, s2, s3);
            e[5] = mul3(c3, s1, s2) - mul2(c1, s3);
            e[6] = -s2;             e[7] = mul2(c2, s3);    e[8] = mul2(c2, c3);
         end
      endcase
      for (int k = 0; k < 9; k++) begin
         matrix[16*k +: 16] = clamp_q15(e[k]);
      end
      return matrix;
   endfunction

   always @(posedge clock) begin
      logic [143:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_matrices.push_back(build_rotation(req_tdata,
                                                       erm_pkg::conv_type'(req_tuser)));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_matrices.size() == 0) begin
               error_count = error_count + 1;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_tdata);
               end
            end else begin
               want = expected_matrices.pop_front();
               checked_count = checked_count + 1;
               for (int k = 0; k < 9; k++) begin
                  if (rsp_tdata[16*k +: 16] !== want[16*k +: 16]) begin
                     error_count = error_count + 1;
                     if (error_count <= MAX_REPORTS) begin
                        $display("%0t: entry r%0d c%0d expected %0d actual %0d", $time,
                                 k / 3, k % 3, $signed(want[16*k +: 16]),
                                 $signed(rsp_tdata[16*k +: 16]));
                     end
                  end
               end
            end
         end
      end
      pending_count = expected_matrices.size();
   end

endmodule

### dv/tb_top.sv
// Testbench top that drives angle beats into the rotation matrix builder and gives the verdict.
module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 1000;
   localparam int HOLD_START   = 300;
   localparam int HOLD_END     = 520;
   localparam int STEADY_START = 1200;
   localparam int STEADY_END   = 1500;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [95:0]   req_tdata;
   logic [2:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [143:0]  rsp_tdata;
   int            error_count;
   int            pending_count;
   int            checked_count;
   int            sent_count;
   int            cycle_count;

   euler_rotation_matrix_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   erm_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_angles(input logic [15:0] c1, input logic [15:0] c2,
                              input logic [15:0] c3, input logic [15:0] s1,
                              input logic [15:0] s2, input logic [15:0] s3,
                              input erm_pkg::conv_type conv);
      req_tdata  <= {s3, s2, s1, c3, c2, c1};
      req_tuser  <= conv;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_count = sent_count + 1;
   endtask

   function automatic logic [15:0] corner_q15();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h8001;
         2: return 16'h7FFF;
         3: return 16'h0000;
         4: return 16'h0001;
         5: return 16'hFFFF;
         6: return 16'h4000;
         default: return 16'hC000;
      endcase
   endfunction

   // The receiver stalls at random, holds off for a long stretch early on so the
   // pipeline fills and backs up into the request side, and later runs without gaps for a stretch.
   initial begin
      int rx_cycle;
      rsp_tready = 1'b0;
      rx_cycle = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         rx_cycle = rx_cycle + 1;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_END) begin
            rsp_tready <= 1'b0;
         end else if (rx_cycle >= STEADY_START && rx_cycle < STEADY_END) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 20);
         end
      end
   end

   initial begin
      logic [15:0] cv[3];
      logic [15:0] sv[3];
      real angle;
      int mode;
      erm_pkg::conv_type conv;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      sent_count = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Every convention at full-scale negative, full-scale positive and a mixed corner.
      for (int k = 0; k < 8; k++) begin
         conv = erm_pkg::conv_type'(k);
         send_angles(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, conv);
         send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, conv);
         send_angles(16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, conv);
      end

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         mode = $urandom_range(99);
         for (int k = 0; k < 3; k++) begin
            if (mode < 60) begin
               angle = $urandom_range(65535) * 6.283185307179586 / 65536.0;
               cv[k] = 16'(int'($cos(angle) * 32767.0));
               sv[k] = 16'(int'($sin(angle) * 32767.0));
            end else if (mode < 85) begin
               cv[k] = 16'($urandom);
               sv[k] = 16'($urandom);
            end else begin
               cv[k] = corner_q15();
               sv[k] = corner_q15();
            end
         end
         conv = erm_pkg::conv_type'($urandom_range(7));
         send_angles(cv[0], cv[1], cv[2], sv[0], sv[1], sv[2], conv);
         if (n < 400 || n >= 600) begin
            while ($urandom_range(99) < 20) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d angle beats over all eight conventions and checked %0d matrices,",
               sent_count, checked_count);
      $display("with full-scale corners, random gaps on both sides and a long output stall.");
      if (error_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
